// ===== design/tst_pkg.sv =====
// Package for the timer slot table: codes, sizes and the controller state type.
// Used by timer_slot_table.sv; depends on nothing else.

package tst_pkg;

  // Table size and tick length
  localparam int SLOTS       = 8;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int MS_PER_TICK = 10;
  localparam int TIME_W      = 32;

  // Period to ticks: reciprocal multiply, exact for every 32-bit period
  localparam int              DIV_SHIFT = TIME_W + $clog2(MS_PER_TICK);
  localparam logic [TIME_W:0] DIV_MAGIC =
    (TIME_W + 1)'(((64'd1 << DIV_SHIFT) / 64'(MS_PER_TICK)) + 64'd1);

  // Operation codes (in_tuser)
  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_RESET  = 3'd2;
  localparam logic [2:0] OP_STOP   = 3'd3;
  localparam logic [2:0] OP_CHANGE = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  // Result status codes (out_tuser)
  localparam logic [2:0] STAT_DONE    = 3'd0;
  localparam logic [2:0] STAT_FULL    = 3'd1;
  localparam logic [2:0] STAT_UNUSED  = 3'd2;
  localparam logic [2:0] STAT_EXPIRED = 3'd3;
  localparam logic [2:0] STAT_IDLE    = 3'd4;

  // Slot modes
  localparam logic [1:0] MODE_PERIODIC  = 2'd0;
  localparam logic [1:0] MODE_ONE_PAUSE = 2'd1;
  localparam logic [1:0] MODE_ONE_FREE  = 2'd2;
  localparam logic [1:0] MODE_ONE_STOP  = 2'd3;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_OP_RD,
    S_OP_WR,
    S_TK_RD,
    S_TK_WR,
    S_TK_END
  } state_t;

endpackage

// ===== design/timer_slot_table.sv =====
// Timer slot table top level: controller, slot flags and the period/count memory.
// Depends on tst_pkg.

// A table of eight timer slots. Period and count of every slot live in one
// synchronous memory (one read, one write per cycle, registered read data);
// the used, mode and paused flags sit in flip-flops cleared by reset, so no
// clearing pass is needed. Create, delete, reset, stop and change period go
// from accept through memory read, then modify and write back, before the
// next accept; create and change period turn milliseconds into ticks with
// a reciprocal multiply during the memory read cycle. A tick walks the slots
// one at a time through the memory, read then write back, then ends in a
// final result state; each expiry is held one slot back so that the final
// result can carry tlast. Both wait while the output register is full and
// not taken and they have a result to hand over.

module timer_slot_table (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // slot[2:0], mode[4:3], period_ms[36:5], now_time[68:37]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // slot_index[2:0]
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast   // last
);

  localparam int TW = tst_pkg::TIME_W;
  localparam int SW = tst_pkg::SLOT_W;

  tst_pkg::state_t state_r, state_nxt;

  // Slot flags
  logic [tst_pkg::SLOTS-1:0] used_r, used_nxt;
  logic [tst_pkg::SLOTS-1:0] paused_r, paused_nxt;
  logic [1:0]                mode_r [tst_pkg::SLOTS];
  logic [1:0]                mode_nxt [tst_pkg::SLOTS];

  // Period/count memory, entry = {period, count}
  logic [2*TW-1:0] mem [tst_pkg::SLOTS];
  logic [2*TW-1:0] rd_data_r;
  logic            rd_en;
  logic [SW-1:0]   rd_addr;
  logic            mem_we;
  logic [SW-1:0]   mem_waddr;
  logic [2*TW-1:0] mem_wdata;

  // Latched transaction
  logic [2:0]    op_r;
  logic [SW-1:0] tgt_r;
  logic [1:0]    mode_in_r;
  logic          full_r;
  logic [TW-1:0] last_time_r;
  logic [TW-1:0] delta_r;

  // Period in ms, then in ticks
  logic [TW-1:0] quo_r;
  logic [2*TW:0] prod;
  logic [TW-1:0] period_ticks;

  // Tick walk
  logic [SW-1:0] walk_r;
  logic          pend_vld_r;
  logic [SW-1:0] pend_slot_r;

  // Output register
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [SW-1:0] out_slot_r;
  logic          out_last_r;
  logic          out_free;
  logic          out_load;
  logic [2:0]    out_status;
  logic [SW-1:0] out_slot;
  logic          out_last;

  // Input fields
  logic [2:0]    in_op;
  logic [SW-1:0] in_slot;
  logic [1:0]    in_mode;
  logic [TW-1:0] in_period;
  logic [TW-1:0] in_now;
  logic          in_acc;

  // Lookup and tick arithmetic
  logic [SW-1:0] free_idx;
  logic [TW-1:0] rd_period;
  logic [TW-1:0] rd_count;
  logic [TW:0]   sum;
  logic [TW-1:0] cnt_sat;
  logic          tk_active;
  logic          tk_exp;
  logic          tk_stall;
  logic          walk_done;
  logic          pend_vld_nxt;

  assign in_op     = in_tuser;
  assign in_slot   = in_tdata[2:0];
  assign in_mode   = in_tdata[4:3];
  assign in_period = in_tdata[36:5];
  assign in_now    = in_tdata[68:37];

  assign in_tready = (state_r == tst_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(8 - SW){1'b0}}, out_slot_r};
  assign out_tlast  = out_last_r;

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = tst_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) free_idx = SW'(i);
    end
  end

  // Milliseconds to ticks: multiply by the scaled reciprocal, keep the high part
  assign prod         = {{(TW + 1){1'b0}}, quo_r} * {{TW{1'b0}}, tst_pkg::DIV_MAGIC};
  assign period_ticks = TW'(prod >> tst_pkg::DIV_SHIFT);

  // Tick arithmetic on the entry just read
  assign rd_period = rd_data_r[2*TW-1:TW];
  assign rd_count  = rd_data_r[TW-1:0];
  assign sum       = {1'b0, rd_count} + {1'b0, delta_r};
  assign cnt_sat   = sum[TW] ? '1 : sum[TW-1:0];
  assign tk_active = used_r[walk_r] && !paused_r[walk_r];
  assign tk_exp    = tk_active && (cnt_sat >= rd_period);
  assign tk_stall  = tk_exp && pend_vld_r && !out_free;
  assign walk_done = (walk_r == SW'(tst_pkg::SLOTS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tst_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_op == tst_pkg::OP_TICK) begin
            state_nxt = tst_pkg::S_TK_RD;
          end else if (in_op == tst_pkg::OP_CREATE || in_op == tst_pkg::OP_CHANGE ||
                       in_op == tst_pkg::OP_DELETE || in_op == tst_pkg::OP_RESET ||
                       in_op == tst_pkg::OP_STOP) begin
            state_nxt = tst_pkg::S_OP_RD;
          end
        end
      end
      tst_pkg::S_OP_RD: state_nxt = tst_pkg::S_OP_WR;
      tst_pkg::S_OP_WR: begin
        if (out_free) state_nxt = tst_pkg::S_IDLE;
      end
      tst_pkg::S_TK_RD: state_nxt = tst_pkg::S_TK_WR;
      tst_pkg::S_TK_WR: begin
        if (!tk_stall) state_nxt = walk_done ? tst_pkg::S_TK_END : tst_pkg::S_TK_RD;
      end
      tst_pkg::S_TK_END: begin
        if (out_free) state_nxt = tst_pkg::S_IDLE;
      end
      default: state_nxt = tst_pkg::S_IDLE;
    endcase
  end

  // Datapath control: memory access, flag updates, results
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = tgt_r;
    mem_we       = 1'b0;
    mem_waddr    = tgt_r;
    mem_wdata    = rd_data_r;
    used_nxt     = used_r;
    paused_nxt   = paused_r;
    mode_nxt     = mode_r;
    out_load     = 1'b0;
    out_status   = tst_pkg::STAT_DONE;
    out_slot     = tgt_r;
    out_last     = 1'b1;
    pend_vld_nxt = pend_vld_r;

    unique case (state_r)
      tst_pkg::S_OP_RD: begin
        rd_en = 1'b1;
      end
      tst_pkg::S_OP_WR: begin
        if (out_free) begin
          out_load = 1'b1;
          if (op_r == tst_pkg::OP_CREATE) begin
            if (full_r) begin
              out_status = tst_pkg::STAT_FULL;
              out_slot   = '0;
            end else begin
              used_nxt[tgt_r]   = 1'b1;
              paused_nxt[tgt_r] = 1'b0;
              mode_nxt[tgt_r]   = mode_in_r;
              mem_we            = 1'b1;
              mem_wdata         = {quo_r, {TW{1'b0}}};
            end
          end else if (!used_r[tgt_r]) begin
            out_status = tst_pkg::STAT_UNUSED;
          end else begin
            case (op_r)
              tst_pkg::OP_DELETE: begin
                used_nxt[tgt_r]   = 1'b0;
                paused_nxt[tgt_r] = 1'b0;
                mode_nxt[tgt_r]   = tst_pkg::MODE_PERIODIC;
              end
              tst_pkg::OP_RESET: begin
                paused_nxt[tgt_r] = 1'b0;
                mem_we            = 1'b1;
                mem_wdata         = {rd_period, {TW{1'b0}}};
              end
              tst_pkg::OP_STOP: begin
                paused_nxt[tgt_r] = 1'b1;
                mem_we            = 1'b1;
                mem_wdata         = {rd_period, {TW{1'b0}}};
              end
              default: begin
                // change period: count restarts only on a new period
                paused_nxt[tgt_r] = 1'b0;
                if (rd_period != quo_r) begin
                  mem_we    = 1'b1;
                  mem_wdata = {quo_r, {TW{1'b0}}};
                end
              end
            endcase
          end
        end
      end
      tst_pkg::S_TK_RD: begin
        rd_en   = 1'b1;
        rd_addr = walk_r;
      end
      tst_pkg::S_TK_WR: begin
        mem_waddr = walk_r;
        if (tk_active && !tk_stall) begin
          mem_we    = 1'b1;
          mem_wdata = {rd_period, tk_exp ? {TW{1'b0}} : cnt_sat};
          if (tk_exp) begin
            // previous expiry goes out now, this one waits for the next
            out_load     = pend_vld_r;
            out_status   = tst_pkg::STAT_EXPIRED;
            out_slot     = pend_slot_r;
            out_last     = 1'b0;
            pend_vld_nxt = 1'b1;
            case (mode_r[walk_r]) inside
              tst_pkg::MODE_ONE_PAUSE, tst_pkg::MODE_ONE_STOP: begin
                paused_nxt[walk_r] = 1'b1;
              end
              tst_pkg::MODE_ONE_FREE: begin
                used_nxt[walk_r]   = 1'b0;
                paused_nxt[walk_r] = 1'b0;
                mode_nxt[walk_r]   = tst_pkg::MODE_PERIODIC;
              end
              default: ;
            endcase
          end
        end
      end
      tst_pkg::S_TK_END: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status   = pend_vld_r ? tst_pkg::STAT_EXPIRED : tst_pkg::STAT_IDLE;
          out_slot     = pend_vld_r ? pend_slot_r : '0;
          pend_vld_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Controller and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tst_pkg::S_IDLE;
      used_r      <= '0;
      paused_r    <= '0;
      last_time_r <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < tst_pkg::SLOTS; i++) mode_r[i] <= tst_pkg::MODE_PERIODIC;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      paused_r   <= paused_nxt;
      mode_r     <= mode_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (in_acc && in_op == tst_pkg::OP_TICK) last_time_r <= in_now;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Transaction payload, period conversion, walk and result registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_op;
      tgt_r     <= (in_op == tst_pkg::OP_CREATE) ? free_idx : in_slot;
      full_r    <= &used_r;
      mode_in_r <= in_mode;
      delta_r   <= in_now - last_time_r;
      quo_r     <= in_period;
      walk_r    <= '0;
    end else if (state_r == tst_pkg::S_OP_RD) begin
      quo_r <= period_ticks;
    end else if (state_r == tst_pkg::S_TK_WR && !tk_stall) begin
      walk_r <= walk_r + 1'b1;
    end
    if (state_r == tst_pkg::S_TK_WR && tk_exp && !tk_stall) pend_slot_r <= walk_r;
    if (out_load) begin
      out_status_r <= out_status;
      out_slot_r   <= out_slot;
      out_last_r   <= out_last;
    end
  end

endmodule

// ===== dv/timer_slot_table_test.sv =====
// Testbench for timer_slot_table: directed and random operation streams with a
// self-checking slot table predictor. Depends on tst_pkg and timer_slot_table.
`timescale 1ns / 1ps

module timer_slot_table_test;

  localparam int         MAX_RES    = 8;     // most results one tick reports
  localparam int         QUIET_MAX  = 5000;  // cycles with no transaction
  localparam int         TAIL_WAIT  = 40;    // longest walk plus margin
  localparam logic [2:0] OP_SPARE_A = 3'd6;  // undefined, ignored by the block
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  // One result transaction as the block should produce it
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] idx;
    logic       last;
  } result_t;

  // Slot table predictor: own copy of the table, queue of expected results
  class slot_table_model;
    bit         used    [tst_pkg::SLOTS];
    logic [1:0] mode_q  [tst_pkg::SLOTS];
    bit         paused  [tst_pkg::SLOTS];
    bit [31:0]  period_q[tst_pkg::SLOTS];
    bit [31:0]  count_q [tst_pkg::SLOTS];
    bit [31:0]  last_time;
    result_t    pending_results[$];
    int         n_errors;
    int         n_requests;
    int         n_results;
    int         n_expired;
    int         n_full;
    int         n_unused;

    function void free_slot(int s);
      used[s]     = 1'b0;
      mode_q[s]   = tst_pkg::MODE_PERIODIC;
      paused[s]   = 1'b0;
      period_q[s] = '0;
      count_q[s]  = '0;
    endfunction

    function void clear_table();
      for (int s = 0; s < tst_pkg::SLOTS; s++) free_slot(s);
      last_time = '0;
    endfunction

    function void push_result(logic [2:0] status, logic [2:0] idx, logic last);
      result_t r;
      r.status = status;
      r.idx    = idx;
      r.last   = last;
      pending_results.push_back(r);
      if (status == tst_pkg::STAT_FULL) n_full++;
      if (status == tst_pkg::STAT_UNUSED) n_unused++;
      if (status == tst_pkg::STAT_EXPIRED) n_expired++;
    endfunction

    // Advance the table by one accepted request, queue what it reports
    function void accept_request(logic [2:0] op, logic [2:0] slot, logic [1:0] mode,
                                 logic [31:0] period_ms, logic [31:0] now_time);
      bit [31:0] ticks;
      bit [31:0] delta;
      bit [32:0] sum;
      bit        found;
      int        hits[$];
      ticks = period_ms / 32'(tst_pkg::MS_PER_TICK);
      found = 1'b0;
      n_requests++;
      case (op) inside
        tst_pkg::OP_CREATE: begin
          for (int s = 0; s < tst_pkg::SLOTS; s++) begin
            if (!found && !used[s]) begin
              found       = 1'b1;
              used[s]     = 1'b1;
              mode_q[s]   = mode;
              paused[s]   = 1'b0;
              period_q[s] = ticks;
              count_q[s]  = '0;
              push_result(tst_pkg::STAT_DONE, 3'(s), 1'b1);
            end
          end
          if (!found) push_result(tst_pkg::STAT_FULL, 3'd0, 1'b1);
        end
        tst_pkg::OP_DELETE, tst_pkg::OP_RESET, tst_pkg::OP_STOP, tst_pkg::OP_CHANGE: begin
          if (int'(slot) >= tst_pkg::SLOTS || !used[slot]) begin
            push_result(tst_pkg::STAT_UNUSED, slot, 1'b1);
          end else begin
            case (op)
              tst_pkg::OP_DELETE: free_slot(slot);
              tst_pkg::OP_RESET: begin
                paused[slot]  = 1'b0;
                count_q[slot] = '0;
              end
              tst_pkg::OP_STOP: begin
                paused[slot]  = 1'b1;
                count_q[slot] = '0;
              end
              default: begin
                // new period clears the count only when it really changes
                if (period_q[slot] != ticks) begin
                  period_q[slot] = ticks;
                  count_q[slot]  = '0;
                end
                paused[slot] = 1'b0;
              end
            endcase
            push_result(tst_pkg::STAT_DONE, slot, 1'b1);
          end
        end
        tst_pkg::OP_TICK: begin
          delta     = now_time - last_time;
          last_time = now_time;
          for (int s = 0; s < tst_pkg::SLOTS; s++) begin
            if (used[s] && !paused[s]) begin
              sum        = {1'b0, count_q[s]} + {1'b0, delta};
              count_q[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
              if (count_q[s] >= period_q[s]) begin
                count_q[s] = '0;
                if (hits.size() < MAX_RES) hits.push_back(s);
                if (mode_q[s] == tst_pkg::MODE_ONE_PAUSE ||
                    mode_q[s] == tst_pkg::MODE_ONE_STOP)
                  paused[s] = 1'b1;
                else if (mode_q[s] == tst_pkg::MODE_ONE_FREE)
                  free_slot(s);
              end
            end
          end
          if (hits.size() == 0)
            push_result(tst_pkg::STAT_IDLE, 3'd0, 1'b1);
          for (int i = 0; i < hits.size(); i++)
            push_result(tst_pkg::STAT_EXPIRED, 3'(hits[i]), i == hits.size() - 1);
        end
        default: ;  // undefined operation: no result, no change
      endcase
    endfunction

    task flag_mismatch(string what, int got, int want);
      n_errors++;
      $display("[%0t] MISMATCH result #%0d: %s got %0d expected %0d",
               $realtime, n_results, what, got, want);
    endtask

    // Compare one accepted result transaction with the oldest expectation
    task check_result(logic [2:0] status, logic [2:0] idx, logic last);
      result_t want;
      n_results++;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, status", status, -1);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) flag_mismatch("status", status, want.status);
        if (idx !== want.idx) flag_mismatch("slot_index", idx, want.idx);
        if (last !== want.last) flag_mismatch("last", last, want.last);
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  slot_table_model table_model;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              quiet_cycles = 0;

  timer_slot_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: check accepted transactions, then pick next ready at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      table_model.check_result(out_tuser, out_tdata[2:0], out_tlast);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_MAX) @(posedge clk);
    $display("Timeout: no transaction for %0d cycles", QUIET_MAX);
    $display("DONE: errors detected");
    $finish;
  end

  task set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Present one request, hold it until taken, then maybe idle a few cycles
  task send_request(logic [2:0] op, logic [2:0] slot, logic [1:0] mode,
                    logic [31:0] period_ms, logic [31:0] now_time);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, now_time, period_ms, mode, slot};
    do @(posedge clk); while (!in_tready);
    table_model.accept_request(op, slot, mode, period_ms, now_time);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  // Hold off the sender until every queued result has come back
  task wait_drained();
    in_tvalid <= 1'b0;
    while (table_model.pending_results.size() != 0) @(posedge clk);
  endtask

  // Pick a slot that is in use most of the time, any slot otherwise
  function logic [2:0] pick_slot();
    int start;
    start = $urandom_range(tst_pkg::SLOTS - 1);
    if ($urandom_range(9) < 8)
      for (int k = 0; k < tst_pkg::SLOTS; k++)
        if (table_model.used[(start + k) % tst_pkg::SLOTS])
          return 3'((start + k) % tst_pkg::SLOTS);
    return 3'(start);
  endfunction

  // Random requests: mostly live slots, short periods and small time steps
  task random_requests(int count);
    int          done_cnt;
    int          roll;
    logic [2:0]  op;
    logic [31:0] period_ms;
    logic [31:0] now_time;
    done_cnt = 0;
    while (done_cnt < count) begin
      roll = $urandom_range(99);
      if (roll < 35) op = tst_pkg::OP_TICK;
      else if (roll < 55) op = tst_pkg::OP_CREATE;
      else if (roll < 68) op = tst_pkg::OP_DELETE;
      else if (roll < 76) op = tst_pkg::OP_RESET;
      else if (roll < 84) op = tst_pkg::OP_STOP;
      else if (roll < 96) op = tst_pkg::OP_CHANGE;
      else op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
      period_ms = ($urandom_range(99) < 85) ? $urandom_range(300) : $urandom();
      roll = $urandom_range(99);
      if (roll < 85) now_time = table_model.last_time + $urandom_range(40);
      else now_time = $urandom();
      send_request(op, pick_slot(), 2'($urandom_range(3)), period_ms, now_time);
      if (op != OP_SPARE_A && op != OP_SPARE_B) done_cnt++;
    end
  endtask

  initial begin
    table_model = new();
    table_model.clear_table();
    set_idling(31, 63);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: idle tick and every slot operation on a free slot
    send_request(tst_pkg::OP_TICK,   3'd0, 2'd0, 32'd0, 32'd0);
    send_request(tst_pkg::OP_DELETE, 3'd0, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(tst_pkg::OP_RESET,  3'd5, 2'd0, 32'd0, 32'd0);
    send_request(tst_pkg::OP_STOP,   3'd7, 2'd1, 32'd0, 32'd0);
    send_request(tst_pkg::OP_CHANGE, 3'd3, 2'd2, 32'd20, 32'd0);
    // Zero period expires even when no time has passed
    send_request(tst_pkg::OP_CREATE, 3'd7, tst_pkg::MODE_PERIODIC, 32'd0, 32'd0);
    send_request(tst_pkg::OP_TICK,   3'd0, 2'd0, 32'd0, 32'd0);
    // Fill the table with every mode, then one create too many
    send_request(tst_pkg::OP_CREATE, 3'd0, tst_pkg::MODE_ONE_PAUSE, 32'd25, 32'd0);
    send_request(tst_pkg::OP_CREATE, 3'd0, tst_pkg::MODE_ONE_FREE,  32'd30, 32'd0);
    send_request(tst_pkg::OP_CREATE, 3'd0, tst_pkg::MODE_ONE_STOP,  32'hFFFF_FFFF, 32'd0);
    send_request(tst_pkg::OP_CREATE, 3'd0, tst_pkg::MODE_PERIODIC,  32'd9, 32'd0);
    send_request(tst_pkg::OP_CREATE, 3'd0, tst_pkg::MODE_PERIODIC,  32'd100, 32'd0);
    send_request(tst_pkg::OP_CREATE, 3'd0, tst_pkg::MODE_ONE_PAUSE, 32'd50, 32'd0);
    send_request(tst_pkg::OP_CREATE, 3'd0, tst_pkg::MODE_ONE_FREE,  32'd1000, 32'd0);
    send_request(tst_pkg::OP_CREATE, 3'd0, tst_pkg::MODE_PERIODIC,  32'd10, 32'd0);
    // Several slots expire on one tick
    send_request(tst_pkg::OP_TICK,   3'd0, 2'd0, 32'd0, 32'd5);
    send_request(tst_pkg::OP_CHANGE, 3'd4, 2'd0, 32'd9, 32'd0);
    send_request(tst_pkg::OP_CHANGE, 3'd5, 2'd0, 32'd200, 32'd0);
    send_request(tst_pkg::OP_RESET,  3'd1, 2'd0, 32'd0, 32'd0);
    send_request(tst_pkg::OP_STOP,   3'd0, 2'd0, 32'd0, 32'd0);
    // Time wraps; the huge delta saturates the long one-shot count
    send_request(tst_pkg::OP_TICK,   3'd0, 2'd0, 32'd0, 32'd1);
    send_request(OP_SPARE_A, 3'd2, 2'd1, 32'h1234_5678, 32'h8765_4321);
    send_request(OP_SPARE_B, 3'd6, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(tst_pkg::OP_DELETE, 3'd3, 2'd0, 32'd0, 32'd0);
    send_request(tst_pkg::OP_TICK,   3'd0, 2'd0, 32'd0, 32'h8000_0000);
    wait_drained();

    random_requests(58);
    wait_drained();
    set_idling(63, 31);
    random_requests(58);
    wait_drained();
    set_idling(0, 0);
    random_requests(58);
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);

    if (table_model.pending_results.size() != 0)
      table_model.flag_mismatch("results never delivered",
                                0, table_model.pending_results.size());
    $display("Covered %0d requests and %0d results: %0d expiries,",
             table_model.n_requests, table_model.n_results, table_model.n_expired);
    $display("  %0d full-table creates, %0d free-slot accesses, three idling mixes",
             table_model.n_full, table_model.n_unused);
    if (table_model.n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
